### sv/rem_pkg.sv
package rem_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_TOUCH  = 3'd1,
    OP_IGNITE = 3'd2,
    OP_BUFFET = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_DUAL   = 2'd0,
    CMD_SINGLE = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_DUAL   = 2'd1,
    MODE_SINGLE = 2'd2
  } mode_e;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 4'd1;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 27;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Pulse coefficients in Q0.16.
  localparam logic [15:0] K_TOUCH_LO  = 16'd55706;
  localparam logic [15:0] K_TOUCH_HI  = 16'd26214;
  localparam logic [15:0] K_IGNITE_LO = 16'd29491;
  localparam logic [15:0] K_IGNITE_HI = 16'd52429;

  localparam logic [17:0] HOLD_TOUCH  = 18'd250000;
  localparam logic [17:0] HOLD_IGNITE = 18'd120000;

  localparam logic [15:0] GAIN_MAX    = 16'd32768;
  localparam logic [15:0] GAIN_RESET  = 16'd16384;
  localparam logic [15:0] BUFFET_MAX  = 16'd4096;
  localparam logic [15:0] AMP_SCALE   = 16'd65535;
  localparam logic [7:0]  DUR_RUMBLE  = 8'd200;
  localparam logic [26:0] ONE_Q26     = 27'd67108864;

endpackage

### sv/rem_if.sv
interface rem_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] intensity;
  logic [19:0] elapsed_us;

  modport source (output valid, op, intensity, elapsed_us, input ready);
  modport sink   (input valid, op, intensity, elapsed_us, output ready);
endinterface

interface rem_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] low_amp;
  logic [15:0] high_amp;
  logic [15:0] magnitude;
  logic [7:0]  duration_ms;

  modport source (output valid, command, low_amp, high_amp, magnitude, duration_ms,
                  input ready);
  modport sink   (input valid, command, low_amp, high_amp, magnitude, duration_ms,
                  output ready);
endinterface

interface rem_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rem_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/rem_mul.sv
module rem_mul (
  input  logic                        clk_i,
  input  logic [rem_pkg::MUL_A_W-1:0] a_i,
  input  logic [rem_pkg::MUL_B_W-1:0] b_i,
  output logic [rem_pkg::MUL_P_W-1:0] p_o
);

  logic [rem_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= rem_pkg::MUL_P_W'(a_i) * rem_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

### sv/rumble_envelope_mixer.sv
// Channel  Direction  Transfer when          Payload
// in_i     sink       valid & ready          op, intensity, elapsed_us
// out_o    source     valid & ready          command, low_amp, high_amp, magnitude,
//                                            duration_ms
// cfg_i    sink       valid & ready          index, data (always ready)
//
// A tick with a device steps through the hold countdown at the transfer, four
// multiplier issues (two gain products, two amplitude scalings), the last registered
// product and the output load. Touchdown and ignite issue two coefficient products;
// a stop with a device just loads the output register; other items end at the
// transfer. A finished result waits in the output register while the next item is
// taken; only a second result stalls. Reset clears levels, hold and output valid.
module rumble_envelope_mixer (
  input  logic      clk_i,
  input  logic      rst_ni,
  rem_in_if.sink    in_i,
  rem_out_if.source out_o,
  rem_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  rem_pkg::op_e        op_q, op_d;
  logic [15:0]         inten_q, inten_d;
  logic [15:0]         gain_q, gain_d;
  logic [1:0]          mode_q, mode_d;
  logic [12:0]         buffet_q, buffet_d;
  logic [15:0]         tlo_q, tlo_d;
  logic [15:0]         thi_q, thi_d;
  logic [17:0]         hold_q, hold_d;
  logic [26:0]         sat_lo_q, sat_lo_d;
  logic [26:0]         sat_hi_q, sat_hi_d;
  logic [15:0]         amp_lo_q, amp_lo_d;
  logic [15:0]         amp_hi_q, amp_hi_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_cmd_q, out_cmd_d;
  logic [15:0]         out_lo_q, out_lo_d;
  logic [15:0]         out_hi_q, out_hi_d;
  logic [15:0]         out_mag_q, out_mag_d;
  logic [7:0]          out_dur_q, out_dur_d;

  logic [rem_pkg::MUL_A_W-1:0] mul_a;
  logic [rem_pkg::MUL_B_W-1:0] mul_b;
  logic [rem_pkg::MUL_P_W-1:0] mul_p;
  logic [rem_pkg::MUL_P_W:0]   round_lvl;
  logic [rem_pkg::MUL_P_W:0]   round_amp;
  logic [26:0]                 sat_p;
  logic [15:0]                 lvl;
  logic [15:0]                 amp;
  logic                        dual, single, is_touch;

  rem_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign dual     = (mode_q == rem_pkg::MODE_DUAL);
  assign single   = (mode_q == rem_pkg::MODE_SINGLE);
  assign is_touch = (op_q == rem_pkg::OP_TOUCH);

  // Rounding and saturation of the registered product.
  assign round_lvl = {1'b0, mul_p} + (rem_pkg::MUL_P_W + 1)'(32768);
  assign lvl       = round_lvl[31:16];
  assign round_amp = {1'b0, mul_p} + (rem_pkg::MUL_P_W + 1)'(33554432);
  assign amp       = round_amp[41:26];
  assign sat_p     = (mul_p > rem_pkg::MUL_P_W'(rem_pkg::ONE_Q26)) ? rem_pkg::ONE_Q26
                                                                   : mul_p[26:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M0: begin
        if (op_q == rem_pkg::OP_TICK) begin
          mul_a = rem_pkg::MUL_A_W'({1'b0, tlo_q} + {4'b0, buffet_q});
          mul_b = gain_q;
        end else begin
          mul_a = rem_pkg::MUL_A_W'(inten_q);
          mul_b = is_touch ? rem_pkg::K_TOUCH_LO : rem_pkg::K_IGNITE_LO;
        end
      end
      S_M1: begin
        if (op_q == rem_pkg::OP_TICK) begin
          mul_a = rem_pkg::MUL_A_W'(thi_q);
          mul_b = gain_q;
        end else begin
          mul_a = rem_pkg::MUL_A_W'(inten_q);
          mul_b = is_touch ? rem_pkg::K_TOUCH_HI : rem_pkg::K_IGNITE_HI;
        end
      end
      S_M2: begin
        mul_a = sat_lo_q;
        mul_b = rem_pkg::AMP_SCALE;
      end
      S_M3: begin
        mul_a = sat_hi_q;
        mul_b = rem_pkg::AMP_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    inten_d     = inten_q;
    gain_d      = gain_q;
    mode_d      = mode_q;
    buffet_d    = buffet_q;
    tlo_d       = tlo_q;
    thi_d       = thi_q;
    hold_d      = hold_q;
    sat_lo_d    = sat_lo_q;
    sat_hi_d    = sat_hi_q;
    amp_lo_d    = amp_lo_q;
    amp_hi_d    = amp_hi_q;
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    out_mag_d   = out_mag_q;
    out_dur_d   = out_dur_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      if (cfg_i.index == rem_pkg::REG_MASTER_GAIN) begin
        gain_d = (cfg_i.data > rem_pkg::GAIN_MAX) ? rem_pkg::GAIN_MAX : cfg_i.data;
      end else if (cfg_i.index == rem_pkg::REG_OUTPUT_MODE) begin
        mode_d = cfg_i.data[1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = rem_pkg::op_e'(in_i.op);
          inten_d = in_i.intensity;
          case (in_i.op)
            rem_pkg::OP_TICK: begin
              if (dual || single) begin
                if (hold_q != '0) begin
                  if (in_i.elapsed_us >= {2'b0, hold_q}) begin
                    hold_d = '0;
                    tlo_d  = '0;
                    thi_d  = '0;
                  end else begin
                    hold_d = hold_q - in_i.elapsed_us[17:0];
                  end
                end
                state_d = S_M0;
              end
            end
            rem_pkg::OP_TOUCH: begin
              if (rem_pkg::HOLD_TOUCH > hold_q) hold_d = rem_pkg::HOLD_TOUCH;
              state_d = S_M0;
            end
            rem_pkg::OP_IGNITE: begin
              if (rem_pkg::HOLD_IGNITE > hold_q) hold_d = rem_pkg::HOLD_IGNITE;
              state_d = S_M0;
            end
            rem_pkg::OP_BUFFET: begin
              buffet_d = (in_i.intensity > rem_pkg::BUFFET_MAX) ? 13'(rem_pkg::BUFFET_MAX)
                                                                : in_i.intensity[12:0];
            end
            rem_pkg::OP_STOP: begin
              buffet_d = '0;
              tlo_d    = '0;
              thi_d    = '0;
              hold_d   = '0;
              amp_lo_d = '0;
              amp_hi_d = '0;
              if (dual || single) state_d = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_M0: begin
        state_d = S_M1;
      end
      S_M1: begin
        if (op_q == rem_pkg::OP_TICK) begin
          sat_lo_d = sat_p;
        end else if (lvl > tlo_q) begin
          tlo_d = lvl;
        end
        state_d = S_M2;
      end
      S_M2: begin
        if (op_q == rem_pkg::OP_TICK) begin
          sat_hi_d = sat_p;
          state_d  = S_M3;
        end else begin
          if (lvl > thi_q) thi_d = lvl;
          state_d = S_IDLE;
        end
      end
      S_M3: begin
        amp_lo_d = amp;
        state_d  = S_M4;
      end
      S_M4: begin
        amp_hi_d = amp;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // The output register takes the result once the previous one is gone.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_lo_d    = amp_lo_q;
          out_hi_d    = amp_hi_q;
          out_mag_d   = (amp_lo_q > amp_hi_q) ? amp_lo_q : amp_hi_q;
          if (op_q == rem_pkg::OP_STOP) begin
            out_cmd_d = single ? rem_pkg::CMD_STOP : rem_pkg::CMD_DUAL;
            out_dur_d = '0;
          end else begin
            out_cmd_d = dual ? rem_pkg::CMD_DUAL : rem_pkg::CMD_SINGLE;
            out_dur_d = rem_pkg::DUR_RUMBLE;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= rem_pkg::OP_TICK;
      gain_q      <= rem_pkg::GAIN_RESET;
      mode_q      <= rem_pkg::MODE_NONE;
      buffet_q    <= '0;
      tlo_q       <= '0;
      thi_q       <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      gain_q      <= gain_d;
      mode_q      <= mode_d;
      buffet_q    <= buffet_d;
      tlo_q       <= tlo_d;
      thi_q       <= thi_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inten_q   <= inten_d;
    sat_lo_q  <= sat_lo_d;
    sat_hi_q  <= sat_hi_d;
    amp_lo_q  <= amp_lo_d;
    amp_hi_q  <= amp_hi_d;
    out_cmd_q <= out_cmd_d;
    out_lo_q  <= out_lo_d;
    out_hi_q  <= out_hi_d;
    out_mag_q <= out_mag_d;
    out_dur_q <= out_dur_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.command     = out_cmd_q;
  assign out_o.low_amp     = out_lo_q;
  assign out_o.high_amp    = out_hi_q;
  assign out_o.magnitude   = out_mag_q;
  assign out_o.duration_ms = out_dur_q;

endmodule

### sv/rem_checker.sv
module rem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_command_i,
  input logic [15:0] out_low_amp_i,
  input logic [15:0] out_high_amp_i,
  input logic [15:0] out_magnitude_i,
  input logic [7:0]  out_duration_ms_i
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // A stalled result keeps its amplitudes, command and duration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_low_amp_i) && $stable(out_high_amp_i)
                                    && $stable(out_command_i)
                                    && $stable(out_duration_ms_i))
    else $error("stalled result changed");

  // The single magnitude is the larger of the two amplitudes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_magnitude_i == ((out_low_amp_i > out_high_amp_i) ? out_low_amp_i
                                                                          : out_high_amp_i))
    else $error("magnitude is not the larger amplitude");

  // A stop carries no amplitude, and only a rumble uses the single play command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_duration_ms_i == 8'd0 |->
      out_low_amp_i == 16'd0 && out_high_amp_i == 16'd0
      && out_command_i != rem_pkg::CMD_SINGLE)
    else $error("stop result carries amplitude");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_command_i == rem_pkg::CMD_STOP |-> out_duration_ms_i == 8'd0)
    else $error("single stop with nonzero duration");

endmodule

bind rumble_envelope_mixer rem_checker u_rem_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_command_i     (out_o.command),
  .out_low_amp_i     (out_o.low_amp),
  .out_high_amp_i    (out_o.high_amp),
  .out_magnitude_i   (out_o.magnitude),
  .out_duration_ms_i (out_o.duration_ms)
);
